@@ hdl/iol_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iol_pkg: shared types and codes for the indexed ordered list
// Operation codes, status codes, default sizes and controller command type.
// ----------------------------------------------------------------------------
package iol_pkg;

  localparam int unsigned DefDepth     = 16;
  localparam int unsigned DefWordWidth = 32;

  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_BACK   = 3'd3;
  localparam logic [2:0] OP_INSERT     = 3'd4;
  localparam logic [2:0] OP_REMOVE     = 3'd5;
  localparam logic [2:0] OP_READ       = 3'd6;
  localparam logic [2:0] OP_CLEAR      = 3'd7;

  localparam logic [1:0] STS_OK    = 2'd0;
  localparam logic [1:0] STS_EMPTY = 2'd1;
  localparam logic [1:0] STS_FULL  = 2'd2;
  localparam logic [1:0] STS_RANGE = 2'd3;

  typedef struct packed {
    logic load;  // capture the accepted item
    logic exec;  // run the operation and load the result register
  } iol_cmd_t;

endpackage

@@ hdl/indexed_ordered_list.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_ordered_list: bounded double-ended queue with indexed access
// Push/pop at either end, insert/remove/read at an index, and clear.
//
// Input channel (in_valid_i/in_ready_o): op_i, position_i, word_in_i.
// Output channel (out_valid_o/out_ready_i): word_out_o, entries_o, status_o.
// Every input transfer yields exactly one output transfer, in order.
//
// The input transfer loads the captured-item registers; the execute state then
// loads the result register once it is free, and raises out_valid_o.
// The controller alternates a capture state and an execute state and takes
// no new item until the last one has executed.
// The slot chain shifts from any index at once, so item position
// does not change the timing.
//
// Reset clears the fill count and both handshakes; slot contents are
// undefined until written and are never shown before that.
// While the receiver stalls, the result register holds; one more item is
// still taken and waits in the execute state until the result drains.
// ----------------------------------------------------------------------------
module indexed_ordered_list
  import iol_pkg::*;
#(
  parameter int unsigned DEPTH      = DefDepth,
  parameter int unsigned WORD_WIDTH = DefWordWidth,
  localparam int unsigned CntW      = $clog2(DEPTH + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [2:0]            op_i,
  input  logic [CntW-1:0]       position_i,
  input  logic [WORD_WIDTH-1:0] word_in_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [WORD_WIDTH-1:0] word_out_o,
  output logic [CntW-1:0]       entries_o,
  output logic [1:0]            status_o
);

  iol_cmd_t cmd;

  iol_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  iol_datapath #(
    .DEPTH      (DEPTH),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .op_i       (op_i),
    .position_i (position_i),
    .word_in_i  (word_in_i),
    .word_out_o (word_out_o),
    .entries_o  (entries_o),
    .status_o   (status_o)
  );

endmodule

@@ hdl/iol_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iol_ctrl: controller for the indexed ordered list
// Two-state sequencer: capture an item, then execute it once the result
// register is free. Owns the handshake of both channels.
// ----------------------------------------------------------------------------
module iol_ctrl
  import iol_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output iol_cmd_t cmd_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;

  always_comb begin
    cmd_o.load  = 1'b0;
    cmd_o.exec  = 1'b0;
    state_d     = state_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    in_ready_o  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.exec  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ hdl/iol_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iol_datapath: slot chain and result register of the indexed ordered list
// Holds the captured item, the fill count and a chain of slots that shifts
// up or down from any index at once.
// ----------------------------------------------------------------------------
module iol_datapath
  import iol_pkg::*;
#(
  parameter int unsigned DEPTH      = DefDepth,
  parameter int unsigned WORD_WIDTH = DefWordWidth,
  localparam int unsigned CntW      = $clog2(DEPTH + 1),
  localparam int unsigned IdxW      = $clog2(DEPTH)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  iol_cmd_t              cmd_i,
  input  logic [2:0]            op_i,
  input  logic [CntW-1:0]       position_i,
  input  logic [WORD_WIDTH-1:0] word_in_i,
  output logic [WORD_WIDTH-1:0] word_out_o,
  output logic [CntW-1:0]       entries_o,
  output logic [1:0]            status_o
);

  logic [2:0]            op_q;
  logic [CntW-1:0]       pos_q;
  logic [WORD_WIDTH-1:0] word_q;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [WORD_WIDTH-1:0] slots_q [DEPTH];
  logic [WORD_WIDTH-1:0] word_out_q;
  logic [CntW-1:0]       entries_q;
  logic [1:0]            status_q;

  logic [1:0]      status_d;
  logic [CntW-1:0] at;
  logic            do_open, do_close, do_read;
  logic            full, empty;

  assign full  = (cnt_q == CntW'(DEPTH));
  assign empty = (cnt_q == '0);

  always_comb begin
    status_d = STS_OK;
    do_open  = 1'b0;
    do_close = 1'b0;
    do_read  = 1'b0;
    at       = '0;
    case (op_q) inside
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        at = (op_q == OP_PUSH_FRONT) ? '0 : cnt_q;
        if (full) status_d = STS_FULL;
        else      do_open  = 1'b1;
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        at = (op_q == OP_POP_FRONT) ? '0 : cnt_q - CntW'(1);
        if (empty) begin
          status_d = STS_EMPTY;
        end else begin
          do_close = 1'b1;
          do_read  = 1'b1;
        end
      end
      OP_INSERT: begin
        at = pos_q;
        if (pos_q > cnt_q) status_d = STS_RANGE;
        else if (full)     status_d = STS_FULL;
        else               do_open  = 1'b1;
      end
      OP_REMOVE, OP_READ: begin
        at = pos_q;
        if (empty) begin
          status_d = STS_EMPTY;
        end else if (pos_q >= cnt_q) begin
          status_d = STS_RANGE;
        end else begin
          do_read  = 1'b1;
          do_close = (op_q == OP_REMOVE);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    if (op_q == OP_CLEAR) cnt_d = '0;
    else if (do_open)     cnt_d = cnt_q + CntW'(1);
    else if (do_close)    cnt_d = cnt_q - CntW'(1);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= op_i;
      pos_q  <= position_i;
      word_q <= word_in_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.exec) begin
      cnt_q <= cnt_d;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_slot
    always_ff @(posedge clk_i) begin
      if (cmd_i.exec) begin
        if (do_open) begin
          if (CntW'(i) == at) begin
            slots_q[i] <= word_q;
          end else if (i > 0 && CntW'(i) > at) begin
            slots_q[i] <= slots_q[(i > 0) ? i - 1 : 0];
          end
        end else if (do_close) begin
          if (i < DEPTH - 1 && CntW'(i) >= at) begin
            slots_q[i] <= slots_q[(i < DEPTH - 1) ? i + 1 : i];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      word_out_q <= do_read ? slots_q[at[IdxW-1:0]] : '0;
      entries_q  <= cnt_d;
      status_q   <= status_d;
    end
  end

  assign word_out_o = word_out_q;
  assign entries_o  = entries_q;
  assign status_o   = status_q;

endmodule

@@ hdl/iol_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iol_checker: port-level checks for the indexed ordered list
// Watches the result channel: counts, status, failed-op words, stall hold.
// ----------------------------------------------------------------------------
module iol_checker
  import iol_pkg::*;
#(
  parameter int unsigned DEPTH      = DefDepth,
  parameter int unsigned WORD_WIDTH = DefWordWidth,
  localparam int unsigned CntW      = $clog2(DEPTH + 1)
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic [WORD_WIDTH-1:0] word_out_o,
  input logic [CntW-1:0]       entries_o,
  input logic [1:0]            status_o
);

  a_entries_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> entries_o <= CntW'(DEPTH))
    else $error("entries above depth");

  a_fail_no_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != STS_OK |-> word_out_o == '0)
    else $error("nonzero word on failed operation");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STS_FULL |-> entries_o == CntW'(DEPTH))
    else $error("full status with room left");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STS_EMPTY |-> entries_o == '0)
    else $error("empty status with words stored");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(word_out_o))
    else $error("result dropped while stalled");

endmodule

bind indexed_ordered_list iol_checker #(
  .DEPTH      (DEPTH),
  .WORD_WIDTH (WORD_WIDTH)
) u_iol_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .word_out_o  (word_out_o),
  .entries_o   (entries_o),
  .status_o    (status_o)
);

@@ tb/indexed_ordered_list_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_ordered_list_tb: self-checking bench for the indexed ordered list
// Drives list operations over the valid/ready input channel and checks each
// output transfer against the bench's shadow copy of the list, or for fixed
// rows the table's reply. A short directed table covers the empty, range and
// index cases, then random phases grow, churn and drain the list under
// random idling on both channels, long receiver hold-offs and drain pauses.
// ----------------------------------------------------------------------------
module indexed_ordered_list_tb;
  import iol_pkg::*;

  localparam int Depth      = DefDepth;
  localparam int WordW      = DefWordWidth;
  localparam int CntW       = $clog2(Depth + 1);
  localparam int NumRows    = 23;
  localparam int NumPhases  = 30;
  localparam int PhaseLen   = 50;
  localparam int HoldCycles = 40;
  localparam int RingDepth  = 64;

  typedef struct packed {
    logic [WordW-1:0] word;
    logic [CntW-1:0]  entries;
    logic [1:0]       status;
  } list_reply_t;

  typedef struct packed {
    logic [2:0]       op;
    logic [CntW-1:0]  pos;
    logic [WordW-1:0] word;
    logic             fixed;
    list_reply_t      reply;
  } stim_row_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [2:0]       op_in = OP_CLEAR;
  logic [CntW-1:0]  pos_in = '0;
  logic [WordW-1:0] word_in = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [WordW-1:0] word_out;
  logic [CntW-1:0]  entries_out;
  logic [1:0]       status_out;

  logic [WordW-1:0] shadow_words [Depth];
  int               shadow_count = 0;
  // expected replies in transfer order
  list_reply_t      reply_ring [RingDepth];
  int unsigned      ring_wr = 0;
  int unsigned      ring_rd = 0;
  int               mismatch_count = 0;
  bit               idle_on = 1'b1;
  bit               hold_req = 1'b0;

  stim_row_t directed_rows [NumRows] = '{
    '{OP_POP_FRONT,  5'd0,  32'h0000_0000, 1'b1, '{32'h0, 5'd0, STS_EMPTY}},
    '{OP_POP_BACK,   5'd0,  32'h0000_0000, 1'b1, '{32'h0, 5'd0, STS_EMPTY}},
    '{OP_REMOVE,     5'd0,  32'h0000_0000, 1'b1, '{32'h0, 5'd0, STS_EMPTY}},
    '{OP_READ,       5'd16, 32'h0000_0000, 1'b1, '{32'h0, 5'd0, STS_EMPTY}},
    '{OP_INSERT,     5'd1,  32'hDEAD_BEEF, 1'b1, '{32'h0, 5'd0, STS_RANGE}},
    '{OP_INSERT,     5'd31, 32'hFFFF_FFFF, 1'b1, '{32'h0, 5'd0, STS_RANGE}},
    '{OP_CLEAR,      5'd0,  32'h0000_0000, 1'b1, '{32'h0, 5'd0, STS_OK}},
    '{OP_INSERT,     5'd0,  32'hFFFF_FFFF, 1'b1, '{32'h0, 5'd1, STS_OK}},
    '{OP_PUSH_FRONT, 5'd0,  32'h0000_0000, 1'b1, '{32'h0, 5'd2, STS_OK}},
    '{OP_PUSH_BACK,  5'd31, 32'hA5A5_A5A5, 1'b1, '{32'h0, 5'd3, STS_OK}},
    '{OP_READ,       5'd0,  32'hFFFF_FFFF, 1'b0, '0},
    '{OP_READ,       5'd3,  32'h0000_0000, 1'b1, '{32'h0, 5'd3, STS_RANGE}},
    '{OP_REMOVE,     5'd31, 32'h0000_0000, 1'b1, '{32'h0, 5'd3, STS_RANGE}},
    '{OP_INSERT,     5'd4,  32'h1111_1111, 1'b1, '{32'h0, 5'd3, STS_RANGE}},
    '{OP_INSERT,     5'd3,  32'h5A5A_5A5A, 1'b0, '0},
    '{OP_INSERT,     5'd1,  32'h1234_5678, 1'b0, '0},
    '{OP_REMOVE,     5'd4,  32'h0000_0000, 1'b0, '0},
    '{OP_REMOVE,     5'd1,  32'h0000_0000, 1'b0, '0},
    '{OP_READ,       5'd2,  32'h0000_0000, 1'b0, '0},
    '{OP_POP_FRONT,  5'd0,  32'h0000_0000, 1'b0, '0},
    '{OP_POP_BACK,   5'd0,  32'h0000_0000, 1'b0, '0},
    '{OP_PUSH_BACK,  5'd0,  32'h0000_0001, 1'b0, '0},
    '{OP_CLEAR,      5'd15, 32'hFFFF_FFFF, 1'b1, '{32'h0, 5'd0, STS_OK}}
  };

  indexed_ordered_list dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .op_i        (op_in),
    .position_i  (pos_in),
    .word_in_i   (word_in),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .word_out_o  (word_out),
    .entries_o   (entries_out),
    .status_o    (status_out)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void open_slot(int at, logic [WordW-1:0] word);
    for (int i = shadow_count; i > at; i--) shadow_words[i] = shadow_words[i-1];
    shadow_words[at] = word;
    shadow_count++;
  endfunction

  function automatic logic [WordW-1:0] close_slot(int at);
    logic [WordW-1:0] word;
    word = shadow_words[at];
    for (int i = at; i + 1 < shadow_count; i++) shadow_words[i] = shadow_words[i+1];
    shadow_count--;
    return word;
  endfunction

  function automatic list_reply_t apply_list_op(logic [2:0] op, logic [CntW-1:0] pos,
                                                logic [WordW-1:0] word);
    list_reply_t r;
    r.word   = '0;
    r.status = STS_OK;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (shadow_count >= Depth) r.status = STS_FULL;
        else open_slot(op == OP_PUSH_FRONT ? 0 : shadow_count, word);
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (shadow_count == 0) r.status = STS_EMPTY;
        else r.word = close_slot(op == OP_POP_FRONT ? 0 : shadow_count - 1);
      end
      OP_INSERT: begin
        if (int'(pos) > shadow_count) r.status = STS_RANGE;
        else if (shadow_count >= Depth) r.status = STS_FULL;
        else open_slot(int'(pos), word);
      end
      OP_REMOVE, OP_READ: begin
        if (shadow_count == 0) r.status = STS_EMPTY;
        else if (int'(pos) >= shadow_count) r.status = STS_RANGE;
        else if (op == OP_REMOVE) r.word = close_slot(int'(pos));
        else r.word = shadow_words[pos];
      end
      default: shadow_count = 0;
    endcase
    r.entries = shadow_count[CntW-1:0];
    return r;
  endfunction

  function automatic logic [2:0] pick_op(int kind);
    int r;
    r = $urandom_range(0, 99);
    if ($urandom_range(0, 49) == 0) return OP_CLEAR;
    if (kind == 0) begin
      if (r < 20) return OP_PUSH_FRONT;
      if (r < 45) return OP_PUSH_BACK;
      if (r < 75) return OP_INSERT;
      if (r < 85) return OP_READ;
      if (r < 92) return OP_REMOVE;
      if (r < 96) return OP_POP_FRONT;
      return OP_POP_BACK;
    end
    if (kind == 2) begin
      if (r < 20) return OP_POP_FRONT;
      if (r < 40) return OP_POP_BACK;
      if (r < 65) return OP_REMOVE;
      if (r < 80) return OP_READ;
      if (r < 88) return OP_PUSH_FRONT;
      if (r < 94) return OP_PUSH_BACK;
      return OP_INSERT;
    end
    return 3'($urandom_range(0, 6));
  endfunction

  // one transfer on the input channel; the reply is predicted at acceptance
  task automatic offer_item(input logic [2:0] op, input logic [CntW-1:0] pos,
                            input logic [WordW-1:0] word, input bit use_fixed,
                            input list_reply_t fixed_reply);
    list_reply_t predicted;
    in_valid <= 1'b1;
    op_in    <= op;
    pos_in   <= pos;
    word_in  <= word;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = apply_list_op(op, pos, word);
    reply_ring[ring_wr[5:0]] = use_fixed ? fixed_reply : predicted;
    ring_wr++;
  endtask

  task automatic sender_gap();
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  initial begin : stimulus
    logic [2:0]       op;
    logic [CntW-1:0]  pos;
    logic [WordW-1:0] word;
    int               kind;
    int               sel;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      offer_item(directed_rows[i].op, directed_rows[i].pos, directed_rows[i].word,
                 directed_rows[i].fixed, directed_rows[i].reply);
      sender_gap();
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      idle_on = (ph < NumPhases - 4) && (ph % 5 != 2);
      if (ph == 3 || ph == 17) hold_req = 1'b1;
      if (ph % 10 == 6) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (ring_wr != ring_rd) @(posedge clk);
      end
      kind = ph % 3;
      for (int i = 0; i < PhaseLen; i++) begin
        op = pick_op(kind);
        if ($urandom_range(0, 4) == 0) pos = CntW'($urandom_range(0, 31));
        else if (op == OP_INSERT) pos = CntW'($urandom_range(0, shadow_count));
        else if (shadow_count > 0) pos = CntW'($urandom_range(0, shadow_count - 1));
        else pos = '0;
        sel = $urandom_range(0, 15);
        word = (sel == 0) ? '0 : (sel == 1) ? '1 : WordW'($urandom);
        offer_item(op, pos, word, 1'b0, '0);
        sender_gap();
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (ring_wr != ring_rd) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : receiver
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        out_ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : reply_check
    list_reply_t want;
    if (rst_n && out_valid && out_ready) begin
      if (ring_wr == ring_rd) begin
        $error("unexpected transfer: word_out %h entries %0d status %0d",
               word_out, entries_out, status_out);
        mismatch_count++;
      end else begin
        want = reply_ring[ring_rd[5:0]];
        ring_rd++;
        if (word_out !== want.word) begin
          $error("word_out: expected %h, got %h", want.word, word_out);
          mismatch_count++;
        end
        if (entries_out !== want.entries) begin
          $error("entries: expected %0d, got %0d", want.entries, entries_out);
          mismatch_count++;
        end
        if (status_out !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_out);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : watchdog
    #3_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/iol_pkg.sv
hdl/iol_ctrl.sv
hdl/iol_datapath.sv
hdl/indexed_ordered_list.sv
hdl/iol_checker.sv
tb/indexed_ordered_list_tb.sv
